// ===== rtl/core/hrhp_pkg.sv =====
// ----------------------------------------------------------------------------
// hrhp_pkg
// shared constants, codes and types of the request header parser
// ----------------------------------------------------------------------------
package hrhp_pkg;

   // sizing defaults
   localparam int HDR_BUF_BYTES       = 4096;
   localparam int FIELD_MAX_BYTES_DEF = 256;
   localparam int LENGTH_DIGITS_DEF   = 15;

   localparam int HDR_LEN_W   = 13;
   localparam int ACC_W       = 50;
   localparam int WIN_BYTES   = 16;

   localparam logic [HDR_LEN_W-1:0] MAX_HDR_RESET   = 13'd4096;
   localparam logic [HDR_LEN_W-1:0] METHOD_BYTES    = 13'd7;
   localparam logic [HDR_LEN_W-1:0] SHORT_HDR_BYTES = 13'd27;
   localparam logic [HDR_LEN_W-1:0] HOST_MIN_IDX    = 13'd21;

   // byte classes
   localparam logic [1:0] CLASS_OTHER = 2'd0;
   localparam logic [1:0] CLASS_URI   = 2'd1;
   localparam logic [1:0] CLASS_HOST  = 2'd2;
   localparam logic [1:0] CLASS_END   = 2'd3;

   // method codes
   localparam logic [3:0] METH_GET     = 4'd0;
   localparam logic [3:0] METH_POST    = 4'd1;
   localparam logic [3:0] METH_HEAD    = 4'd2;
   localparam logic [3:0] METH_OPTIONS = 4'd3;
   localparam logic [3:0] METH_PUT     = 4'd4;
   localparam logic [3:0] METH_TRACE   = 4'd5;
   localparam logic [3:0] METH_DELETE  = 4'd6;
   localparam logic [3:0] METH_CONNECT = 4'd7;
   localparam logic [3:0] METH_UNKNOWN = 4'd8;

   // parse status
   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_NO_METHOD = 2'd1;
   localparam logic [1:0] ST_BAD_REQ   = 2'd2;
   localparam logic [1:0] ST_TOO_LARGE = 2'd3;

   // field tracking phase
   typedef enum logic [2:0] {
      PH_IDLE    = 3'b001,
      PH_COLLECT = 3'b010,
      PH_DONE    = 3'b100
   } phase_type;

endpackage

// ===== rtl/core/http_request_header_parser.sv =====
// ----------------------------------------------------------------------------
// http_request_header_parser
// byte-wide request header parser with method, host, uri and length decode
// ----------------------------------------------------------------------------
// One header byte enters per request on req_data_byte (req_valid/req_stall).
// Each accepted byte produces one response on the rsp_ channel: the byte
// echoed with its class (other, uri, host value, header end). On the byte
// that completes CR LF CR LF, or that brings the header to the size limit,
// the response carries header_done with method, content length, header
// length and status, and the parser rearms for the next header.
// The response is registered: it is loaded into the output register at the
// edge that takes the byte.
// Throughput is one byte per cycle while no response is held by rsp_stall,
// set by the single pass of window compares and the times-ten length add.
// The csr_ channel writes max_header_bytes; it is always ready. The user must
// see that it is written only between requests; the block does not enforce it.
// Reset clears all parse state, empties the output register and sets
// max_header_bytes to 4096. While rsp_stall holds a response, req_stall is
// raised and the response holds; with rsp_stall low a byte is taken in
// every cycle.
// ----------------------------------------------------------------------------
module http_request_header_parser #(
   parameter int FIELD_MAX_BYTES = hrhp_pkg::FIELD_MAX_BYTES_DEF,
   parameter int LENGTH_DIGITS   = hrhp_pkg::LENGTH_DIGITS_DEF
) (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,

   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_byte_class,
   output logic [7:0]  rsp_echo_byte,
   output logic [3:0]  rsp_method_code,
   output logic [49:0] rsp_body_length,
   output logic [12:0] rsp_header_length,
   output logic [1:0]  rsp_parse_status,
   output logic        rsp_header_done,

   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [12:0] csr_max_header_bytes
);

   localparam int LW = hrhp_pkg::HDR_LEN_W;
   localparam int AW = hrhp_pkg::ACC_W;
   localparam int CW = $clog2(FIELD_MAX_BYTES + 1);
   localparam int DW = $clog2(LENGTH_DIGITS + 1);
   localparam int RW = 8 * (hrhp_pkg::WIN_BYTES - 1);
   localparam int BufCap = (hrhp_pkg::HDR_BUF_BYTES > 8191) ? 8191 : hrhp_pkg::HDR_BUF_BYTES;
   localparam logic [LW-1:0] BUF_CAP = LW'(BufCap);
   localparam logic [CW-1:0] FIELD_MAX = CW'(FIELD_MAX_BYTES);
   localparam logic [DW-1:0] DIGIT_MAX = DW'(LENGTH_DIGITS);
   localparam logic [31:0]  PAT_END  = 32'h0d0a0d0a;
   localparam logic [47:0]  PAT_HOST = "Host: ";
   localparam logic [127:0] PAT_LEN  = "Content-Length: ";

   // state
   logic [LW-1:0]       max_hdr_ff;
   logic [LW-1:0]       byte_cnt_ff, byte_cnt_in;
   logic [RW-1:0]       recent_ff, recent_in;
   logic [3:0]          method_ff, method_in;
   hrhp_pkg::phase_type uri_ph_ff, uri_ph_in;
   logic [CW-1:0]       uri_cnt_ff, uri_cnt_in;
   hrhp_pkg::phase_type host_ph_ff, host_ph_in;
   logic [CW-1:0]       host_cnt_ff, host_cnt_in;
   hrhp_pkg::phase_type len_ph_ff, len_ph_in;
   logic [AW-1:0]       acc_ff, acc_in;
   logic [DW-1:0]       dig_cnt_ff, dig_cnt_in;

   // response register
   logic        rsp_valid_ff;
   logic [1:0]  cls_ff, cls_in;
   logic [7:0]  echo_ff;
   logic [3:0]  meth_out_ff, meth_out_in;
   logic [49:0] clen_ff, clen_in;
   logic [12:0] hlen_ff, hlen_in;
   logic [1:0]  stat_ff, stat_in;
   logic        done_ff, done_in;

   logic           accept;
   logic [7:0]     c;
   logic [127:0]   win;
   logic [LW-1:0]  n;
   logic [LW-1:0]  limit;
   logic [3:0]     decoded;
   logic [1:0]     cls_c;
   logic           is_digit;
   logic           at_limit;
   logic [CW-1:0]  uri_cnt_inc;
   logic [CW-1:0]  host_cnt_inc;
   logic [DW-1:0]  dig_cnt_inc;

   assign csr_ready = 1'b1;
   assign req_stall = rsp_valid_ff & rsp_stall;
   assign accept    = req_valid & ~req_stall;

   assign c     = req_data_byte;
   assign win   = {recent_ff, c};
   assign n     = byte_cnt_ff + 1'b1;
   assign limit = (max_hdr_ff > BUF_CAP) ? BUF_CAP : max_hdr_ff;
   assign is_digit = (c >= 8'h30) && (c <= 8'h39);
   assign uri_cnt_inc  = uri_cnt_ff + 1'b1;
   assign host_cnt_inc = host_cnt_ff + 1'b1;
   assign dig_cnt_inc  = dig_cnt_ff + 1'b1;

   // method from the first seven bytes, first byte at window byte 6
   always_comb begin
      if (win[55:32] == "GET") begin
         decoded = hrhp_pkg::METH_GET;
      end else if (win[55:24] == "POST") begin
         decoded = hrhp_pkg::METH_POST;
      end else if (win[55:24] == "HEAD") begin
         decoded = hrhp_pkg::METH_HEAD;
      end else if (win[55:0] == "OPTIONS") begin
         decoded = hrhp_pkg::METH_OPTIONS;
      end else if (win[55:32] == "PUT") begin
         decoded = hrhp_pkg::METH_PUT;
      end else if (win[55:16] == "TRACE") begin
         decoded = hrhp_pkg::METH_TRACE;
      end else if (win[55:8] == "DELETE") begin
         decoded = hrhp_pkg::METH_DELETE;
      end else if (win[55:0] == "CONNECT") begin
         decoded = hrhp_pkg::METH_CONNECT;
      end else begin
         decoded = hrhp_pkg::METH_UNKNOWN;
      end
   end

   always_comb begin
      cls_c       = hrhp_pkg::CLASS_OTHER;
      recent_in   = win[RW-1:0];
      method_in   = (n == hrhp_pkg::METHOD_BYTES) ? decoded : method_ff;
      uri_ph_in   = uri_ph_ff;
      uri_cnt_in  = uri_cnt_ff;
      host_ph_in  = host_ph_ff;
      host_cnt_in = host_cnt_ff;
      len_ph_in   = len_ph_ff;
      acc_in      = acc_ff;
      dig_cnt_in  = dig_cnt_ff;
      byte_cnt_in = n;

      // uri
      case (uri_ph_ff)
         hrhp_pkg::PH_IDLE: begin
            if (c == 8'h20) uri_ph_in = hrhp_pkg::PH_COLLECT;
         end
         hrhp_pkg::PH_COLLECT: begin
            if (c == 8'h20 || c == 8'h0d || c == 8'h0a) begin
               uri_ph_in = hrhp_pkg::PH_DONE;
            end else begin
               cls_c      = hrhp_pkg::CLASS_URI;
               uri_cnt_in = uri_cnt_inc;
               if (uri_cnt_inc >= FIELD_MAX) uri_ph_in = hrhp_pkg::PH_DONE;
            end
         end
         default: ;
      endcase

      // host value
      case (host_ph_ff)
         hrhp_pkg::PH_IDLE: begin
            if (byte_cnt_ff >= hrhp_pkg::HOST_MIN_IDX && win[47:0] == PAT_HOST)
               host_ph_in = hrhp_pkg::PH_COLLECT;
         end
         hrhp_pkg::PH_COLLECT: begin
            if (c == 8'h0d) begin
               host_ph_in = hrhp_pkg::PH_DONE;
            end else begin
               if (cls_c == hrhp_pkg::CLASS_OTHER) cls_c = hrhp_pkg::CLASS_HOST;
               host_cnt_in = host_cnt_inc;
               if (host_cnt_inc >= FIELD_MAX) host_ph_in = hrhp_pkg::PH_DONE;
            end
         end
         default: ;
      endcase

      // content length
      case (len_ph_ff)
         hrhp_pkg::PH_IDLE: begin
            if (win == PAT_LEN) len_ph_in = hrhp_pkg::PH_COLLECT;
         end
         hrhp_pkg::PH_COLLECT: begin
            if (is_digit && dig_cnt_ff < DIGIT_MAX) begin
               acc_in     = (acc_ff << 3) + (acc_ff << 1) + AW'(c[3:0]);
               dig_cnt_in = dig_cnt_inc;
               if (dig_cnt_inc >= DIGIT_MAX) len_ph_in = hrhp_pkg::PH_DONE;
            end else begin
               len_ph_in = hrhp_pkg::PH_DONE;
            end
         end
         default: ;
      endcase

      // header end
      at_limit    = (n >= limit);
      done_in     = at_limit || (win[31:0] == PAT_END);
      cls_in      = cls_c;
      meth_out_in = 4'd0;
      clen_in     = '0;
      hlen_in     = '0;
      stat_in     = hrhp_pkg::ST_OK;
      if (done_in) begin
         cls_in      = hrhp_pkg::CLASS_END;
         meth_out_in = (n >= hrhp_pkg::METHOD_BYTES) ? method_in : hrhp_pkg::METH_UNKNOWN;
         clen_in     = acc_in;
         hlen_in     = n;
         if (at_limit) begin
            stat_in = hrhp_pkg::ST_TOO_LARGE;
         end else if (n < hrhp_pkg::METHOD_BYTES) begin
            stat_in = hrhp_pkg::ST_BAD_REQ;
         end else if (meth_out_in == hrhp_pkg::METH_UNKNOWN) begin
            stat_in = hrhp_pkg::ST_NO_METHOD;
         end else if (n <= hrhp_pkg::SHORT_HDR_BYTES || host_ph_in == hrhp_pkg::PH_IDLE) begin
            stat_in = hrhp_pkg::ST_BAD_REQ;
         end
         // rearm
         byte_cnt_in = '0;
         recent_in   = '0;
         method_in   = 4'd0;
         uri_ph_in   = hrhp_pkg::PH_IDLE;
         uri_cnt_in  = '0;
         host_ph_in  = hrhp_pkg::PH_IDLE;
         host_cnt_in = '0;
         len_ph_in   = hrhp_pkg::PH_IDLE;
         acc_in      = '0;
         dig_cnt_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_hdr_ff  <= hrhp_pkg::MAX_HDR_RESET;
         byte_cnt_ff <= '0;
         recent_ff   <= '0;
         method_ff   <= 4'd0;
         uri_ph_ff   <= hrhp_pkg::PH_IDLE;
         uri_cnt_ff  <= '0;
         host_ph_ff  <= hrhp_pkg::PH_IDLE;
         host_cnt_ff <= '0;
         len_ph_ff   <= hrhp_pkg::PH_IDLE;
         acc_ff      <= '0;
         dig_cnt_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) max_hdr_ff <= csr_max_header_bytes;
         if (accept) begin
            byte_cnt_ff  <= byte_cnt_in;
            recent_ff    <= recent_in;
            method_ff    <= method_in;
            uri_ph_ff    <= uri_ph_in;
            uri_cnt_ff   <= uri_cnt_in;
            host_ph_ff   <= host_ph_in;
            host_cnt_ff  <= host_cnt_in;
            len_ph_ff    <= len_ph_in;
            acc_ff       <= acc_in;
            dig_cnt_ff   <= dig_cnt_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cls_ff      <= cls_in;
         echo_ff     <= c;
         meth_out_ff <= meth_out_in;
         clen_ff     <= clen_in;
         hlen_ff     <= hlen_in;
         stat_ff     <= stat_in;
         done_ff     <= done_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_byte_class     = cls_ff;
   assign rsp_echo_byte      = echo_ff;
   assign rsp_method_code    = meth_out_ff;
   assign rsp_body_length    = clen_ff;
   assign rsp_header_length  = hlen_ff;
   assign rsp_parse_status   = stat_ff;
   assign rsp_header_done    = done_ff;

   // checks
   a_done_class: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (done_ff == (cls_ff == hrhp_pkg::CLASS_END)))
      else $error("header end flag and class disagree");

   a_summary_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !done_ff) |-> (hlen_ff == '0 && clen_ff == '0 && meth_out_ff == 4'd0))
      else $error("summary fields set before header end");

   a_rearm: assert property (@(posedge clock) disable iff (reset)
      (accept && done_in) |=> (byte_cnt_ff == '0 && recent_ff == '0))
      else $error("parser not rearmed after header end");

   a_uri_bound: assert property (@(posedge clock) disable iff (reset)
      (uri_ph_ff == hrhp_pkg::PH_COLLECT) |-> (uri_cnt_ff < FIELD_MAX))
      else $error("uri count past field limit");

endmodule

// ===== bench/hrhp_result_checker.sv =====
// ----------------------------------------------------------------------------
// hrhp_result_checker
// watches the request, response and csr channels of the header parser. every
// accepted request byte runs through a local parser model, and every accepted
// response is compared field by field with the oldest predicted response
// ----------------------------------------------------------------------------
module hrhp_result_checker (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [7:0]  req_data_byte,

   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [1:0]  rsp_byte_class,
   input  logic [7:0]  rsp_echo_byte,
   input  logic [3:0]  rsp_method_code,
   input  logic [49:0] rsp_body_length,
   input  logic [12:0] rsp_header_length,
   input  logic [1:0]  rsp_parse_status,
   input  logic        rsp_header_done,

   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [12:0] csr_max_header_bytes,

   output int          mismatch_count,
   output int          pending_count
);

   localparam logic [7:0] CHAR_CR = 8'h0D;
   localparam logic [7:0] CHAR_LF = 8'h0A;
   localparam logic [7:0] CHAR_SP = 8'h20;

   typedef struct packed {
      logic [1:0]  byte_class;
      logic [7:0]  echo_byte;
      logic [3:0]  method_code;
      logic [49:0] body_length;
      logic [12:0] header_length;
      logic [1:0]  parse_status;
      logic        header_done;
   } parse_result_type;

   parse_result_type pending_results[$];

   logic [12:0]         max_bytes;
   logic [12:0]         bytes_seen;
   logic [7:0]          recent [hrhp_pkg::WIN_BYTES];
   logic [3:0]          method_seen;
   hrhp_pkg::phase_type uri_ph;
   hrhp_pkg::phase_type host_ph;
   hrhp_pkg::phase_type len_ph;
   logic [8:0]          uri_len;
   logic [8:0]          host_len;
   logic [49:0]         length_acc;
   logic [3:0]          digits_seen;

   int fail_total = 0;
   int queued = 0;
   int rsp_index = 0;

   assign mismatch_count = fail_total;
   assign pending_count  = queued;

   function automatic void clear_header();
      bytes_seen = '0;
      for (int k = 0; k < hrhp_pkg::WIN_BYTES; k++) recent[k] = 8'h00;
      method_seen = hrhp_pkg::METH_GET;
      uri_ph      = hrhp_pkg::PH_IDLE;
      host_ph     = hrhp_pkg::PH_IDLE;
      len_ph      = hrhp_pkg::PH_IDLE;
      uri_len     = '0;
      host_len    = '0;
      length_acc  = '0;
      digits_seen = '0;
   endfunction

   function automatic bit tail_match(string pat);
      int n;
      n = pat.len();
      for (int k = 0; k < n; k++)
         if (recent[k] != pat[n-1-k]) return 1'b0;
      return 1'b1;
   endfunction

   function automatic bit head_match(string pat);
      for (int k = 0; k < pat.len(); k++)
         if (recent[6-k] != pat[k]) return 1'b0;
      return 1'b1;
   endfunction

   function automatic parse_result_type parse_byte(logic [7:0] c);
      parse_result_type r;
      int idx;
      int n;
      int lim;
      logic [1:0] cls;
      logic [3:0] meth;
      logic [1:0] st;
      idx = bytes_seen;
      n   = idx + 1;
      lim = (max_bytes > hrhp_pkg::HDR_BUF_BYTES) ? hrhp_pkg::HDR_BUF_BYTES : max_bytes;
      cls = hrhp_pkg::CLASS_OTHER;
      for (int k = hrhp_pkg::WIN_BYTES - 1; k > 0; k--) recent[k] = recent[k-1];
      recent[0] = c;

      if (n == hrhp_pkg::METHOD_BYTES) begin
         if (head_match("GET")) method_seen = hrhp_pkg::METH_GET;
         else if (head_match("POST")) method_seen = hrhp_pkg::METH_POST;
         else if (head_match("HEAD")) method_seen = hrhp_pkg::METH_HEAD;
         else if (head_match("OPTIONS")) method_seen = hrhp_pkg::METH_OPTIONS;
         else if (head_match("PUT")) method_seen = hrhp_pkg::METH_PUT;
         else if (head_match("TRACE")) method_seen = hrhp_pkg::METH_TRACE;
         else if (head_match("DELETE")) method_seen = hrhp_pkg::METH_DELETE;
         else if (head_match("CONNECT")) method_seen = hrhp_pkg::METH_CONNECT;
         else method_seen = hrhp_pkg::METH_UNKNOWN;
      end

      if (uri_ph == hrhp_pkg::PH_COLLECT) begin
         if (c == CHAR_SP || c == CHAR_CR || c == CHAR_LF) begin
            uri_ph = hrhp_pkg::PH_DONE;
         end else begin
            cls = hrhp_pkg::CLASS_URI;
            uri_len++;
            if (uri_len >= hrhp_pkg::FIELD_MAX_BYTES_DEF) uri_ph = hrhp_pkg::PH_DONE;
         end
      end else if (uri_ph == hrhp_pkg::PH_IDLE && c == CHAR_SP) begin
         uri_ph = hrhp_pkg::PH_COLLECT;
      end

      if (host_ph == hrhp_pkg::PH_COLLECT) begin
         if (c == CHAR_CR) begin
            host_ph = hrhp_pkg::PH_DONE;
         end else begin
            if (cls == hrhp_pkg::CLASS_OTHER) cls = hrhp_pkg::CLASS_HOST;
            host_len++;
            if (host_len >= hrhp_pkg::FIELD_MAX_BYTES_DEF) host_ph = hrhp_pkg::PH_DONE;
         end
      end else if (host_ph == hrhp_pkg::PH_IDLE && idx >= hrhp_pkg::HOST_MIN_IDX &&
                   tail_match("Host: ")) begin
         host_ph = hrhp_pkg::PH_COLLECT;
      end

      if (len_ph == hrhp_pkg::PH_COLLECT) begin
         if (c >= 8'h30 && c <= 8'h39 && digits_seen < hrhp_pkg::LENGTH_DIGITS_DEF) begin
            length_acc = length_acc * 10 + (c - 8'h30);
            digits_seen++;
            if (digits_seen >= hrhp_pkg::LENGTH_DIGITS_DEF) len_ph = hrhp_pkg::PH_DONE;
         end else begin
            len_ph = hrhp_pkg::PH_DONE;
         end
      end else if (len_ph == hrhp_pkg::PH_IDLE && tail_match("Content-Length: ")) begin
         len_ph = hrhp_pkg::PH_COLLECT;
      end

      r = '0;
      r.echo_byte = c;
      if (n >= lim || tail_match("\015\012\015\012")) begin
         meth = (n >= hrhp_pkg::METHOD_BYTES) ? method_seen : hrhp_pkg::METH_UNKNOWN;
         if (n >= lim) st = hrhp_pkg::ST_TOO_LARGE;
         else if (n < hrhp_pkg::METHOD_BYTES) st = hrhp_pkg::ST_BAD_REQ;
         else if (meth == hrhp_pkg::METH_UNKNOWN) st = hrhp_pkg::ST_NO_METHOD;
         else if (n <= hrhp_pkg::SHORT_HDR_BYTES || host_ph == hrhp_pkg::PH_IDLE)
            st = hrhp_pkg::ST_BAD_REQ;
         else st = hrhp_pkg::ST_OK;
         r.byte_class    = hrhp_pkg::CLASS_END;
         r.method_code   = meth;
         r.body_length   = length_acc;
         r.header_length = n[12:0];
         r.parse_status  = st;
         r.header_done   = 1'b1;
         clear_header();
      end else begin
         bytes_seen   = n[12:0];
         r.byte_class = cls;
      end
      return r;
   endfunction

   task automatic report_mismatch(string msg);
      fail_total++;
      $display("mismatch: %s", msg);
   endtask

   task automatic compare_field(string name, logic [49:0] got, logic [49:0] exp);
      if (got !== exp)
         report_mismatch($sformatf("response %0d %s: got 0x%0h, expected 0x%0h",
                                   rsp_index, name, got, exp));
   endtask

   always @(posedge clock) begin : monitor
      parse_result_type want;
      if (reset) begin
         max_bytes = hrhp_pkg::MAX_HDR_RESET;
         clear_header();
         pending_results.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_results.size() == 0) begin
               report_mismatch($sformatf("response %0d with no request pending", rsp_index));
            end else begin
               want = pending_results.pop_front();
               compare_field("byte_class", 50'(rsp_byte_class), 50'(want.byte_class));
               compare_field("echo_byte", 50'(rsp_echo_byte), 50'(want.echo_byte));
               compare_field("method_code", 50'(rsp_method_code), 50'(want.method_code));
               compare_field("body_length", rsp_body_length, want.body_length);
               compare_field("header_length", 50'(rsp_header_length),
                             50'(want.header_length));
               compare_field("parse_status", 50'(rsp_parse_status), 50'(want.parse_status));
               compare_field("header_done", 50'(rsp_header_done), 50'(want.header_done));
            end
            rsp_index++;
         end
         if (req_valid && !req_stall) pending_results.push_back(parse_byte(req_data_byte));
         if (csr_valid && csr_ready) max_bytes = csr_max_header_bytes;
      end
      queued = pending_results.size();
   end

endmodule

// ===== bench/tb_http_request_header_parser.sv =====
// ----------------------------------------------------------------------------
// tb_http_request_header_parser
// drives request headers byte by byte into the parser: a few short directed
// headers, then mostly well-formed random headers mixed with noise and cut-off
// headers, over several header size limits and idle patterns on both sides.
// the checker beside the block predicts and compares every response
// ----------------------------------------------------------------------------
module tb_http_request_header_parser;

   localparam int QUIET_LIMIT = 2000;
   localparam int PHASE_BYTES = 200;
   localparam int LONG_BYTES  = 200;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_data_byte = 8'h00;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [1:0]  rsp_byte_class;
   logic [7:0]  rsp_echo_byte;
   logic [3:0]  rsp_method_code;
   logic [49:0] rsp_body_length;
   logic [12:0] rsp_header_length;
   logic [1:0]  rsp_parse_status;
   logic        rsp_header_done;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [12:0] csr_max_header_bytes = 13'd0;

   int mismatch_count;
   int pending_count;
   int send_gap_pct = 0;
   int hold_pct = 0;
   int sent_bytes = 0;
   logic [7:0] hdr_bytes[$];

   http_request_header_parser DUT (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_data_byte        (req_data_byte),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_byte_class       (rsp_byte_class),
      .rsp_echo_byte        (rsp_echo_byte),
      .rsp_method_code      (rsp_method_code),
      .rsp_body_length      (rsp_body_length),
      .rsp_header_length    (rsp_header_length),
      .rsp_parse_status     (rsp_parse_status),
      .rsp_header_done      (rsp_header_done),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_max_header_bytes (csr_max_header_bytes)
   );

   hrhp_result_checker result_check (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_data_byte        (req_data_byte),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_byte_class       (rsp_byte_class),
      .rsp_echo_byte        (rsp_echo_byte),
      .rsp_method_code      (rsp_method_code),
      .rsp_body_length      (rsp_body_length),
      .rsp_header_length    (rsp_header_length),
      .rsp_parse_status     (rsp_parse_status),
      .rsp_header_done      (rsp_header_done),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_max_header_bytes (csr_max_header_bytes),
      .mismatch_count       (mismatch_count),
      .pending_count        (pending_count)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(0, 99) < hold_pct);
   end

   task automatic push_text(string s);
      for (int k = 0; k < s.len(); k++) hdr_bytes.push_back(s[k]);
   endtask

   task automatic push_random(int count, logic [7:0] lo, logic [7:0] hi);
      for (int k = 0; k < count; k++) hdr_bytes.push_back(8'($urandom_range(hi, lo)));
   endtask

   // called at a falling edge, returns at the falling edge after acceptance
   task automatic send_byte(logic [7:0] b);
      while ($urandom_range(0, 99) < send_gap_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_data_byte <= b;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
      sent_bytes++;
   endtask

   task automatic send_header();
      while (hdr_bytes.size() > 0) send_byte(hdr_bytes.pop_front());
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
   endtask

   task automatic csr_write(logic [12:0] value);
      csr_valid            <= 1'b1;
      csr_max_header_bytes <= value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic build_request();
      int kind;
      int rot;
      int keep;
      hdr_bytes.delete();
      kind = $urandom_range(0, 99);
      if (kind < 12) begin
         push_random($urandom_range(1, 40), 8'h00, 8'hFF);
         if ($urandom_range(0, 1)) push_text("\015\012\015\012");
      end else begin
         case ($urandom_range(0, 10))
            0: push_text("GET");
            1: push_text("POST");
            2: push_text("HEAD");
            3: push_text("OPTIONS");
            4: push_text("PUT");
            5: push_text("TRACE");
            6: push_text("DELETE");
            7: push_text("CONNECT");
            8: push_text("BREW");
            9: push_text("get");
            default: push_random($urandom_range(1, 8), 8'h41, 8'h5A);
         endcase
         push_text(" /");
         push_random(($urandom_range(0, 19) == 0) ? $urandom_range(250, 300)
                                                 : $urandom_range(0, 24), 8'h21, 8'h7E);
         if ($urandom_range(0, 9) != 0) push_text(" HTTP/1.1");
         push_text("\015\012");
         rot = $urandom_range(0, 2);
         for (int s = 0; s < 3; s++) begin
            case ((s + rot) % 3)
               0: if ($urandom_range(0, 6) != 0) begin
                  push_text("Host: ");
                  push_random(($urandom_range(0, 19) == 0) ? $urandom_range(250, 300)
                                                          : $urandom_range(0, 20), 8'h20, 8'h7E);
                  push_text("\015\012");
               end
               1: if ($urandom_range(0, 1)) begin
                  push_text(($urandom_range(0, 7) == 0) ? "content-length: " : "Content-Length: ");
                  if ($urandom_range(0, 9) == 0) push_text("999999999999999");
                  else push_random($urandom_range(0, 17), 8'h30, 8'h39);
                  if ($urandom_range(0, 3) == 0) push_text("x");
                  push_text("\015\012");
               end
               default: if ($urandom_range(0, 1)) push_text("Accept: */*\015\012");
            endcase
         end
         push_text("\015\012");
         if (kind < 20) begin
            keep = $urandom_range(0, hdr_bytes.size() - 1);
            while (hdr_bytes.size() > keep) hdr_bytes.delete(hdr_bytes.size() - 1);
            push_text("\015\012\015\012");
         end
      end
   endtask

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
             (csr_valid && csr_ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("http_request_header_parser regression: fail");
      $finish;
   end

   initial begin : stimulus
      logic [12:0] limit_value;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      send_gap_pct = 26;
      hold_pct     = 80;

      // extreme bytes in a short header, unknown method, known method too short
      hdr_bytes.delete();
      hdr_bytes.push_back(8'h00);
      hdr_bytes.push_back(8'hFF);
      push_text("\015\012\015\012");
      push_text("BREW / \015\012\015\012");
      push_text("PUT /\015\012\015\012");
      send_header();

      for (int phase = 0; phase < 6; phase++) begin
         drain();
         case (phase)
            0: limit_value = 13'd17;
            1: limit_value = 13'd4096;
            2: limit_value = 13'($urandom_range(17, 4096));
            3: limit_value = 13'd60;
            4: limit_value = 13'd300;
            default: limit_value = 13'd4096;
         endcase
         csr_write(limit_value);
         send_gap_pct = (phase < 2) ? 26 : (phase < 4) ? 80 : 0;
         hold_pct     = (phase < 2) ? 80 : (phase < 4) ? 26 : 0;
         sent_bytes   = 0;
         while (sent_bytes < PHASE_BYTES) begin
            build_request();
            send_header();
         end
      end

      // one long header that runs into the size limit
      drain();
      csr_write(13'(LONG_BYTES));
      hdr_bytes.delete();
      push_text("\015\012\015\012");
      push_random(LONG_BYTES, 8'h20, 8'h7E);
      send_header();

      drain();
      repeat (4) @(negedge clock);
      if (mismatch_count == 0)
         $display("http_request_header_parser regression: pass");
      else
         $display("http_request_header_parser regression: fail");
      $finish;
   end

endmodule
